FILE: sv/ppts_pkg.sv
// ----------------------------------------------------------------------------
// ppts_pkg: shared types and codes of the priority periodic task scheduler
// Holds the word structs, command and status codes, and the cell bus types.
// ----------------------------------------------------------------------------
package ppts_pkg;

    localparam logic [1:0] CMD_SET      = 2'd0;
    localparam logic [1:0] CMD_DELETE   = 2'd1;
    localparam logic [1:0] CMD_TICK     = 2'd2;
    localparam logic [1:0] CMD_DISPATCH = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_NULL_ID   = 2'd3;

    localparam logic [1:0] OP_NOP    = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_RELOAD = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  task_id;
        logic [31:0] start_delay;
        logic [31:0] run_period;
        logic [7:0]  task_priority;
    } t_in_word;

    typedef struct packed {
        logic       run_valid;
        logic [7:0] run_id;
        logic       pend_request;
        logic [3:0] task_count;
        logic [1:0] status;
    } t_out_word;

    typedef struct packed {
        logic [7:0]  id;
        logic [31:0] delay;
        logic [31:0] period;
        logic [7:0]  prio;
        logic        ready;
    } t_slot;

    // Running result of the walk along the chain.
    typedef struct packed {
        logic       found;
        logic [7:0] prio;
        logic [7:0] id;
        logic       zero_period;
        logic       pend;
    } t_scan;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic [1:0] op;
        logic [1:0] command;
        logic [7:0] key_id;
        t_slot      slot;
    } t_cell_ctl;

endpackage

FILE: sv/ppts_cell.sv
// ----------------------------------------------------------------------------
// ppts_cell: one table slot of the scheduler
// Holds one task and passes the registered search result to its neighbor.
// ----------------------------------------------------------------------------
module ppts_cell #(
    parameter int IW = 3
) (
    input  logic                 i_clk,
    input  logic [IW-1:0]        i_my_idx,
    input  logic                 i_used,
    input  ppts_pkg::t_cell_ctl  i_ctl,
    input  logic [IW-1:0]        i_tgt_idx,
    input  ppts_pkg::t_scan      i_scan,
    input  logic [IW-1:0]        i_scan_idx,
    output ppts_pkg::t_scan      o_scan,
    output logic [IW-1:0]        o_scan_idx,
    output ppts_pkg::t_slot      o_slot
);

    ppts_pkg::t_slot r_slot;
    ppts_pkg::t_scan r_scan;
    ppts_pkg::t_scan n_scan;
    logic [IW-1:0]   r_scan_idx;
    logic [IW-1:0]   n_scan_idx;
    logic            w_hit;
    logic            w_cand;

    assign w_hit = (i_tgt_idx == i_my_idx);

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            ppts_pkg::OP_WRITE: begin
                if (w_hit) begin
                    r_slot <= i_ctl.slot;
                end
            end
            ppts_pkg::OP_TICK: begin
                if (i_used) begin
                    if (r_slot.delay == 32'd0) begin
                        r_slot.ready <= 1'b1;
                    end else begin
                        r_slot.delay <= r_slot.delay - 32'd1;
                    end
                end
            end
            ppts_pkg::OP_RELOAD: begin
                if (w_hit) begin
                    if (r_slot.delay == 32'd0) begin
                        r_slot.delay <= r_slot.period - 32'd1;
                    end
                    r_slot.ready <= 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // Take over the search result when this slot beats what came from the left.
    always_comb begin
        case (i_ctl.command)
            ppts_pkg::CMD_SET,
            ppts_pkg::CMD_DELETE:   w_cand = i_used && !i_scan.found &&
                                             (r_slot.id == i_ctl.key_id);
            ppts_pkg::CMD_DISPATCH: w_cand = i_used && r_slot.ready &&
                                             (!i_scan.found || (r_slot.prio > i_scan.prio));
            default:                w_cand = 1'b0;
        endcase
        n_scan      = i_scan;
        n_scan_idx  = i_scan_idx;
        n_scan.pend = i_scan.pend | (i_used & (r_slot.ready | (r_slot.delay == 32'd0)));
        if (w_cand) begin
            n_scan.found       = 1'b1;
            n_scan.prio        = r_slot.prio;
            n_scan.id          = r_slot.id;
            n_scan.zero_period = (r_slot.period == 32'd0);
            n_scan_idx         = i_my_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan     <= n_scan;
        r_scan_idx <= n_scan_idx;
    end

    assign o_scan     = r_scan;
    assign o_scan_idx = r_scan_idx;
    assign o_slot     = r_slot;

endmodule

FILE: sv/priority_periodic_task_scheduler_unit.sv
// ----------------------------------------------------------------------------
// priority_periodic_task_scheduler_unit: table of periodic tasks with dispatch
// Set, delete, tick and dispatch commands over a row of slot cells.
// ----------------------------------------------------------------------------
// Each command word goes from acceptance through the scan state, in which
// the search result walks the row of slot cells one cell per cycle, to the
// commit state, which applies the change and loads the result word.
// The input side stalls while a command is in work and opens again the cycle
// after the change is applied, so a new word is taken only once the previous
// command is through. A finished result waits in the output register
// while the next command is taken; the apply cycle of that next command holds
// until the output register is free. Slot contents are undefined after reset;
// only the table's task count is cleared; only slots below it are ever looked at.
module priority_periodic_task_scheduler_unit #(
    parameter int TABLE_SLOTS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  ppts_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output ppts_pkg::t_out_word  o_out_word
);

    localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CW = $clog2(TABLE_SLOTS + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic [IW-1:0]       r_step;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    ppts_pkg::t_in_word  r_cmd;
    ppts_pkg::t_slot     r_last;
    logic                r_out_valid;
    ppts_pkg::t_out_word r_out;
    ppts_pkg::t_out_word n_out;

    ppts_pkg::t_cell_ctl w_ctl;
    logic [IW-1:0]       w_tgt;
    ppts_pkg::t_scan     w_scan     [TABLE_SLOTS];
    logic [IW-1:0]       w_scan_idx [TABLE_SLOTS];
    ppts_pkg::t_slot     w_slot     [TABLE_SLOTS];
    ppts_pkg::t_scan     w_end;
    logic [IW-1:0]       w_end_idx;
    logic [CW-1:0]       w_last_cnt;
    logic [IW-1:0]       w_last_idx;
    logic                w_commit;
    logic [CW+3:0]       w_cnt_ext;

    assign w_end     = w_scan[TABLE_SLOTS-1];
    assign w_end_idx = w_scan_idx[TABLE_SLOTS-1];

    // Row of slot cells: cell 0 starts the walk from an empty result.
    for (genvar k = 0; k < TABLE_SLOTS; k++) begin : g_cell
        ppts_pkg::t_scan w_in;
        logic [IW-1:0]   w_in_idx;
        if (k == 0) begin : g_head
            assign w_in     = '0;
            assign w_in_idx = '0;
        end else begin : g_link
            assign w_in     = w_scan[k-1];
            assign w_in_idx = w_scan_idx[k-1];
        end
        ppts_cell #(.IW(IW)) u_cell (
            .i_clk      (i_clk),
            .i_my_idx   (IW'(k)),
            .i_used     (CW'(k) < r_count),
            .i_ctl      (w_ctl),
            .i_tgt_idx  (w_tgt),
            .i_scan     (w_in),
            .i_scan_idx (w_in_idx),
            .o_scan     (w_scan[k]),
            .o_scan_idx (w_scan_idx[k]),
            .o_slot     (w_slot[k])
        );
    end

    assign o_in_stall = (r_state != S_IDLE);
    // Apply the change only when the output register is free to take the result.
    assign w_commit   = (r_state == S_COMMIT) && (!r_out_valid || !i_out_stall);

    assign w_last_cnt = r_count - CW'(1);
    assign w_last_idx = (r_count == '0) ? '0 : w_last_cnt[IW-1:0];

    always_comb begin
        n_state         = r_state;
        n_count         = r_count;
        n_out           = '0;
        w_tgt           = w_end_idx;
        w_ctl.op        = ppts_pkg::OP_NOP;
        w_ctl.command   = r_cmd.command;
        w_ctl.key_id    = r_cmd.task_id;
        w_ctl.slot.id     = r_cmd.task_id;
        w_ctl.slot.delay  = r_cmd.start_delay;
        w_ctl.slot.period = r_cmd.run_period;
        w_ctl.slot.prio   = r_cmd.task_priority;
        w_ctl.slot.ready  = 1'b0;
        n_out.status    = ppts_pkg::ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_step == IW'(TABLE_SLOTS - 1)) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                    case (r_cmd.command)
                        ppts_pkg::CMD_SET: begin
                            if (r_cmd.task_id == 8'd0) begin
                                n_out.status = ppts_pkg::ST_NULL_ID;
                            end else if (w_end.found) begin
                                w_ctl.op = ppts_pkg::OP_WRITE;
                            end else if (r_count < CW'(TABLE_SLOTS)) begin
                                // Append at the first free slot.
                                w_ctl.op = ppts_pkg::OP_WRITE;
                                w_tgt    = r_count[IW-1:0];
                                n_count  = r_count + CW'(1);
                            end else begin
                                n_out.status = ppts_pkg::ST_FULL;
                            end
                        end
                        ppts_pkg::CMD_DELETE: begin
                            if (r_cmd.task_id == 8'd0) begin
                                n_out.status = ppts_pkg::ST_NULL_ID;
                            end else if (!w_end.found) begin
                                n_out.status = ppts_pkg::ST_NOT_FOUND;
                            end else begin
                                // Move the last task into the freed slot.
                                w_ctl.op   = ppts_pkg::OP_WRITE;
                                w_ctl.slot = r_last;
                                n_count    = w_last_cnt;
                            end
                        end
                        ppts_pkg::CMD_TICK: begin
                            w_ctl.op           = ppts_pkg::OP_TICK;
                            n_out.pend_request = w_end.pend;
                        end
                        default: begin
                            if (w_end.found) begin
                                n_out.run_valid = 1'b1;
                                n_out.run_id    = w_end.id;
                                if (w_end.zero_period) begin
                                    // One-shot task: drop it after this run.
                                    w_ctl.op   = ppts_pkg::OP_WRITE;
                                    w_ctl.slot = r_last;
                                    n_count    = w_last_cnt;
                                end else begin
                                    w_ctl.op = ppts_pkg::OP_RELOAD;
                                end
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        w_cnt_ext        = {4'b0, n_count};
        n_out.task_count = w_cnt_ext[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == S_IDLE) begin
                r_step <= '0;
            end else if (r_state == S_SCAN) begin
                r_step <= r_step + IW'(1);
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_cmd <= i_in_word;
        end
        if (r_state == S_SCAN) begin
            r_last <= w_slot[w_last_idx];
        end
        if (w_commit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule
